// ===== rtl/thmr_pkg.sv =====
// thmr_pkg: shared widths, constants, codes and controller/datapath interface types
// for the triangle height max raster block. No dependencies.
package thmr_pkg;

  localparam int W_POS = 41;   // post position
  localparam int W_DIF = 42;   // post minus first vertex
  localparam int W_VEC = 33;   // edge vectors and height deltas
  localparam int W_T   = 77;   // d, vn, un and multiplier operand A
  localparam int W_MB  = 34;   // magnitude of multiplier operand B
  localparam int W_DIG = 17;   // multiplier digit of B
  localparam int W_PP  = W_T + W_DIG;
  localparam int W_P   = 111;  // unsigned product magnitude
  localparam int W_ACC = 112;  // signed accumulator
  localparam int W_R   = 68;   // divider remainder
  localparam int W_Q   = 33;   // quotient bits
  localparam int W_Z   = 35;   // height sum before saturation

  localparam logic signed [31:0] NODATA = -32'sd8388352;  // -32767.0 in Q.8

  localparam logic [1:0] FUNC_TRI   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] REG_SPACING_X = 2'd0;
  localparam logic [1:0] REG_SPACING_Y = 2'd1;
  localparam logic [1:0] REG_ORIGIN_X  = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Y  = 2'd3;

  // product terms in issue order
  typedef enum logic [2:0] {
    TERM_VX_UY, TERM_VY_UX, TERM_DPX_UY, TERM_DPY_UX,
    TERM_DPY_VX, TERM_DPX_VY, TERM_UN_UZ, TERM_VN_VZ
  } term_t;

  typedef struct packed {
    logic  capture;
    logic  pos;
    logic  diff;
    logic  mul_hi;
    logic  mul_lo;
    logic  mac;
    logic  norm;
    logic  test;
    logic  div_init;
    logic  div_step;
    logic  zsum;
    logic  mem_rd;
    logic  mem_wr;
    logic  clr_step;
    term_t term;
  } thmr_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       d_zero;
    logic       tri_ok;
    logic       clr_last;
  } thmr_sts_t;

endpackage

// ===== rtl/thmr_ctrl.sv =====
// thmr_ctrl: sequencer for the triangle height max raster datapath.
// Depends on thmr_pkg (command/status structs, term codes).
module thmr_ctrl
  import thmr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  thmr_sts_t sts,
  output thmr_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_POS, ST_DIFF, ST_MHI, ST_MLO, ST_MACC,
    ST_CHECK, ST_TEST, ST_DINIT, ST_DSTEP, ST_ZSUM, ST_MRD, ST_MWR
  } state_t;

  localparam int W_CNT = $clog2(W_Q);

  state_t           st, st_next;
  term_t            term, term_next;
  logic [W_CNT-1:0] dcnt, dcnt_next;
  logic             out_valid_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (st == ST_IDLE);

  always_comb begin
    st_next   = st;
    term_next = term;
    dcnt_next = dcnt;
    cmd       = '0;
    cmd.term  = term;
    unique case (st)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) st_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          st_next     = ST_POS;
        end
      end
      ST_POS: begin
        cmd.pos = 1'b1;
        st_next = (sts.func == FUNC_TRI) ? ST_DIFF : ST_MRD;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        term_next = TERM_VX_UY;
        st_next   = ST_MHI;
      end
      ST_MHI: begin
        cmd.mul_hi = 1'b1;
        st_next    = ST_MLO;
      end
      ST_MLO: begin
        cmd.mul_lo = 1'b1;
        st_next    = ST_MACC;
      end
      ST_MACC: begin
        cmd.mac = 1'b1;
        if (term == TERM_DPX_VY) begin
          st_next = ST_CHECK;
        end else if (term == TERM_VN_VZ) begin
          st_next = ST_DINIT;
        end else begin
          term_next = term_t'(term + 3'd1);
          st_next   = ST_MHI;
        end
      end
      ST_CHECK: begin
        cmd.norm = 1'b1;
        st_next  = sts.d_zero ? ST_MRD : ST_TEST;
      end
      ST_TEST: begin
        cmd.test = 1'b1;
        if (sts.tri_ok) begin
          term_next = TERM_UN_UZ;
          st_next   = ST_MHI;
        end else begin
          st_next = ST_MRD;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        dcnt_next    = W_CNT'(W_Q - 1);
        st_next      = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.div_step = 1'b1;
        if (dcnt == '0) st_next = ST_ZSUM;
        else dcnt_next = dcnt - 1'b1;
      end
      ST_ZSUM: begin
        cmd.zsum = 1'b1;
        st_next  = ST_MRD;
      end
      ST_MRD: begin
        cmd.mem_rd = 1'b1;
        st_next    = ST_MWR;
      end
      ST_MWR: begin
        if (out_free) begin
          cmd.mem_wr = 1'b1;
          st_next    = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.mem_wr) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_CLEAR;
      term      <= TERM_VX_UY;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      term      <= term_next;
      dcnt      <= dcnt_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_wr |-> (!out_valid || out_ready)) else $error("result loaded over pending result");
  a_mlo_after_mhi: assert property (@(posedge clk) disable iff (rst)
    (st == ST_MLO) |-> ($past(st) == ST_MHI)) else $error("low digit without high digit");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DSTEP && dcnt == '0) |=> (st == ST_ZSUM)) else $error("divider step count");
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (st == ST_CLEAR) |-> (!out_valid && !in_ready)) else $error("traffic during grid clear");

endmodule

// ===== rtl/thmr_dp.sv =====
// thmr_dp: datapath of the triangle height max raster: config registers, post position,
// shared digit-serial multiplier/accumulator, serial divider, height grid memory.
// Depends on thmr_pkg.
module thmr_dp
  import thmr_pkg::*;
#(
  parameter int GRID_ROWS = 256,
  parameter int GRID_COLS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         func,
  input  logic [7:0]         row,
  input  logic [7:0]         col,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by_pos,
  input  logic signed [31:0] bz,
  input  logic signed [31:0] cx,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] cz,
  input  thmr_cmd_t          cmd,
  output thmr_sts_t          sts,
  output logic               hit,
  output logic signed [31:0] interp_height,
  output logic signed [31:0] cell_height
);

  localparam int DEPTH = GRID_ROWS * GRID_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [W_Z-1:0] Z_MAX = 35'sd2147483647;
  localparam logic signed [W_Z-1:0] Z_MIN = -35'sd2147483648;

  // config
  logic [30:0]        spacing_x, spacing_y;
  logic signed [31:0] origin_x, origin_y;

  // captured item
  logic [1:0]         func_r;
  logic [7:0]         row_r, col_r;
  logic signed [31:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r, cx_r, cy_r, cz_r;

  // geometry
  logic signed [W_POS-1:0] px, py;
  logic [AW-1:0]           addr;
  logic                    on_grid;
  logic signed [W_DIF-1:0] dpx, dpy;
  logic signed [W_VEC-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [W_T-1:0]   d, vn, un;

  // multiplier / accumulator
  logic signed [W_T-1:0]   a_sel;
  logic signed [W_VEC-1:0] b_sel;
  logic [W_T-1:0]          mag_a;
  logic [W_MB-1:0]         b_ext, mag_b;
  logic [W_DIG-1:0]        dig;
  logic [W_PP-1:0]         pp;
  logic [W_P-1:0]          preg;
  logic                    p_neg;
  logic signed [W_ACC-1:0] acc, acc_base, acc_next, addend;
  logic                    acc_clr, acc_sub, add_neg;

  // test
  logic signed [W_T:0] uv_sum;
  logic                tri_ok;
  logic                hit_r;

  // divider
  logic [W_ACC-1:0] mag_num;
  logic             num_neg;
  logic [W_R-1:0]   rem, trial, dd;
  logic [W_Q-1:0]   nsh, q;
  logic [W_Z-1:0]   q_ext;
  logic signed [W_Z-1:0] qs, zs;
  logic signed [31:0]    z_r;

  // grid memory
  logic signed [31:0] grid_mem [DEPTH];
  logic signed [31:0] rd_data, cell_new, cell_out, wd;
  logic [AW-1:0]      clr_cnt, wa;
  logic               we;
  logic [38:0]        sx_col, sy_row;
  logic [31:0]        addr_full;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_x <= 31'd256;
      spacing_y <= 31'd256;
      origin_x  <= '0;
      origin_y  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPACING_X: spacing_x <= cfg_data[30:0];
        REG_SPACING_Y: spacing_y <= cfg_data[30:0];
        REG_ORIGIN_X:  origin_x  <= $signed(cfg_data);
        REG_ORIGIN_Y:  origin_y  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign sx_col    = spacing_x * col_r;
  assign sy_row    = spacing_y * row_r;
  assign addr_full = 32'(row_r) * 32'(GRID_COLS) + 32'(col_r);

  // operand select per product term
  always_comb begin
    case (cmd.term)
      TERM_VX_UY:  begin a_sel = W_T'(vx);  b_sel = uy; end
      TERM_VY_UX:  begin a_sel = W_T'(vy);  b_sel = ux; end
      TERM_DPX_UY: begin a_sel = W_T'(dpx); b_sel = uy; end
      TERM_DPY_UX: begin a_sel = W_T'(dpy); b_sel = ux; end
      TERM_DPY_VX: begin a_sel = W_T'(dpy); b_sel = vx; end
      TERM_DPX_VY: begin a_sel = W_T'(dpx); b_sel = vy; end
      TERM_UN_UZ:  begin a_sel = un;        b_sel = uz; end
      default:     begin a_sel = vn;        b_sel = vz; end
    endcase
    acc_clr = (cmd.term == TERM_VX_UY) || (cmd.term == TERM_DPX_UY) ||
              (cmd.term == TERM_DPY_VX) || (cmd.term == TERM_UN_UZ);
    acc_sub = (cmd.term == TERM_VY_UX) || (cmd.term == TERM_DPY_UX) ||
              (cmd.term == TERM_DPX_VY);
  end

  assign mag_a    = a_sel[W_T-1] ? W_T'(-a_sel) : W_T'(a_sel);
  assign b_ext    = W_MB'(b_sel);
  assign mag_b    = b_sel[W_VEC-1] ? (~b_ext + 1'b1) : b_ext;
  assign dig      = cmd.mul_hi ? mag_b[W_MB-1:W_DIG] : mag_b[W_DIG-1:0];
  assign pp       = mag_a * dig;
  assign add_neg  = acc_sub ^ p_neg;
  assign acc_base = acc_clr ? '0 : acc;
  assign addend   = $signed({1'b0, preg} ^ {W_ACC{add_neg}});
  assign acc_next = acc_base + addend + W_ACC'(add_neg);

  // inside test on normalized values
  assign uv_sum = {un[W_T-1], un} + {vn[W_T-1], vn};
  assign tri_ok = !un[W_T-1] && !vn[W_T-1] && ($signed({d[W_T-1], d}) >= uv_sum);

  // divider
  assign mag_num = acc[W_ACC-1] ? W_ACC'(-acc) : W_ACC'(acc);
  assign trial   = {rem[W_R-2:0], nsh[W_Q-1]};
  assign dd      = d[W_R-1:0];
  assign q_ext   = {2'b00, q};
  assign qs      = num_neg ? $signed(-q_ext) : $signed(q_ext);
  assign zs      = W_Z'(az_r) + qs;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func;
      row_r  <= row;
      col_r  <= col;
      ax_r <= ax; ay_r <= ay; az_r <= az;
      bx_r <= bx; by_r <= by_pos; bz_r <= bz;
      cx_r <= cx; cy_r <= cy; cz_r <= cz;
      hit_r <= 1'b0;
      z_r   <= NODATA;
    end
    if (cmd.pos) begin
      px      <= $signed({2'b00, sx_col}) + W_POS'(origin_x);
      py      <= $signed({2'b00, sy_row}) + W_POS'(origin_y);
      addr    <= addr_full[AW-1:0];
      on_grid <= (32'(row_r) < 32'(GRID_ROWS)) && (32'(col_r) < 32'(GRID_COLS));
    end
    if (cmd.diff) begin
      dpx <= W_DIF'(px) - W_DIF'(ax_r);
      dpy <= W_DIF'(py) - W_DIF'(ay_r);
      ux  <= W_VEC'(bx_r) - W_VEC'(ax_r);
      uy  <= W_VEC'(by_r) - W_VEC'(ay_r);
      uz  <= W_VEC'(bz_r) - W_VEC'(az_r);
      vx  <= W_VEC'(cx_r) - W_VEC'(ax_r);
      vy  <= W_VEC'(cy_r) - W_VEC'(ay_r);
      vz  <= W_VEC'(cz_r) - W_VEC'(az_r);
    end
    if (cmd.mul_hi) begin
      preg  <= W_P'(pp);
      p_neg <= a_sel[W_T-1] ^ b_sel[W_VEC-1];
    end
    if (cmd.mul_lo) preg <= (preg << W_DIG) + W_P'(pp);
    if (cmd.mac) begin
      acc <= acc_next;
      case (cmd.term)
        TERM_VY_UX:  d  <= acc_next[W_T-1:0];
        TERM_DPY_UX: vn <= acc_next[W_T-1:0];
        TERM_DPX_VY: un <= acc_next[W_T-1:0];
        default: ;
      endcase
    end
    if (cmd.norm && d[W_T-1]) begin
      d  <= -d;
      vn <= -vn;
      un <= -un;
    end
    if (cmd.test) hit_r <= tri_ok;
    if (cmd.div_init) begin
      num_neg <= acc[W_ACC-1];
      rem     <= W_R'(mag_num >> W_Q);
      nsh     <= mag_num[W_Q-1:0];
      q       <= '0;
    end
    if (cmd.div_step) begin
      nsh <= nsh << 1;
      if (trial >= dd) begin
        rem <= trial - dd;
        q   <= {q[W_Q-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[W_Q-2:0], 1'b0};
      end
    end
    if (cmd.zsum) begin
      if (zs > Z_MAX) z_r <= 32'sh7fffffff;
      else if (zs < Z_MIN) z_r <= 32'sh80000000;
      else z_r <= 32'(zs);
    end
  end

  // cell update
  always_comb begin
    case (func_r)
      FUNC_TRI:   cell_new = (hit_r && (z_r > rd_data)) ? z_r : rd_data;
      FUNC_CLEAR: cell_new = NODATA;
      default:    cell_new = rd_data;
    endcase
    cell_out = on_grid ? cell_new : NODATA;
  end

  assign we = cmd.clr_step || (cmd.mem_wr && on_grid);
  assign wa = cmd.clr_step ? clr_cnt : addr;
  assign wd = cmd.clr_step ? NODATA : cell_new;

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_data <= grid_mem[addr];
    if (we) grid_mem[wa] <= wd;
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      hit           <= hit_r;
      interp_height <= hit_r ? z_r : NODATA;
      cell_height   <= cell_out;
    end
  end

  assign sts.func     = func_r;
  assign sts.d_zero   = (d == '0);
  assign sts.tri_ok   = tri_ok;
  assign sts.clr_last = (clr_cnt == AW'(DEPTH - 1));

endmodule

// ===== rtl/triangle_height_max_raster.sv =====
// triangle_height_max_raster: top level; stream ports, config port, controller and datapath.
// Depends on thmr_pkg, thmr_ctrl, thmr_dp.
//
// Usage
//   Input stream (s_axis_*): one item per transfer. tuser carries the operation
//   (test triangle and keep max, read cell, clear cell). tdata carries the post
//   and the three triangle vertices in Q.8.
//   Output stream (m_axis_*): exactly one result per item, in order. tuser is the
//   hit flag, tdata the interpolated height and the cell value after the item.
//   Config port: cfg_we writes cfg_data into register cfg_index;
//   write only while no item is in flight.
// Sequencing (one item in flight at a time)
//   read / clear: capture, post position, memory read, memory write.
//   triangle test: a miss ends after the inside test (a degenerate triangle after
//   the d check); a hit adds two products, the divider and the sum. The rate is
//   set by the shared multiplier (8 products, 17-bit digits) and the radix-2
//   divider (33 steps). The next item is taken the cycle after the result loads.
// Reset: the grid is swept to no-data (-32767.0), one cell per cycle,
//   GRID_ROWS*GRID_COLS cells; s_axis_tready stays low during the sweep.
// Stall: a finished result sits in the output register; the next item is still
//   accepted and worked on, and only its result waits until m_axis_tready.
module triangle_height_max_raster
  import thmr_pkg::*;
#(
  parameter int GRID_ROWS = 256,
  parameter int GRID_COLS = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [303:0] s_axis_tdata,   // row, col, ax, ay, az, bx, by_pos, bz, cx, cy, cz
  input  logic [1:0]   s_axis_tuser,   // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // interp_height, cell_height
  output logic         m_axis_tuser,   // hit
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  thmr_cmd_t          cmd;
  thmr_sts_t          sts;
  logic signed [31:0] interp_height, cell_height;

  thmr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  thmr_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .func          (s_axis_tuser),
    .row           (s_axis_tdata[7:0]),
    .col           (s_axis_tdata[15:8]),
    .ax            ($signed(s_axis_tdata[47:16])),
    .ay            ($signed(s_axis_tdata[79:48])),
    .az            ($signed(s_axis_tdata[111:80])),
    .bx            ($signed(s_axis_tdata[143:112])),
    .by_pos        ($signed(s_axis_tdata[175:144])),
    .bz            ($signed(s_axis_tdata[207:176])),
    .cx            ($signed(s_axis_tdata[239:208])),
    .cy            ($signed(s_axis_tdata[271:240])),
    .cz            ($signed(s_axis_tdata[303:272])),
    .cmd           (cmd),
    .sts           (sts),
    .hit           (m_axis_tuser),
    .interp_height (interp_height),
    .cell_height   (cell_height)
  );

  assign m_axis_tdata = {cell_height, interp_height};

endmodule

// ===== tb/sv/triangle_height_max_raster_test.sv =====
`timescale 1ns / 1ps
// triangle_height_max_raster_test: self-checking bench for the triangle height max raster.
// Depends on thmr_pkg and triangle_height_max_raster; predicts every result in the bench.
module triangle_height_max_raster_test
  import thmr_pkg::*;
();

  localparam int ROWS = 256;
  localparam int COLS = 256;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct {
    logic [1:0] func;
    logic [7:0] row;
    logic [7:0] col;
    logic signed [31:0] v [9];  // ax ay az bx by bz cx cy cz
  } tri_item_t;

  typedef struct {
    logic hit;
    logic signed [31:0] interp;
    logic signed [31:0] cell_val;
  } height_res_t;

  // directed row: item plus optional typed-in expectation
  typedef struct {
    tri_item_t item;
    bit has_exp;
    height_res_t exp;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [303:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #2 clk = ~clk;

  triangle_height_max_raster u_top (.*);

  // predictor state
  logic signed [31:0] grid_q8 [ROWS*COLS];
  logic [30:0] sp_x, sp_y;
  logic signed [31:0] org_x, org_y;

  height_res_t pending_heights[$];
  int errors = 0;
  bit stim_done = 0;
  longint cycles = 0;
  int out_wait = 0;

  // exact barycentric test in wide integers
  function automatic height_res_t predict_height(tri_item_t it);
    height_res_t r;
    logic signed [127:0] px, py, ax, ay, az, ux, uy, uz, vx, vy, vz, dpx, dpy;
    logic signed [127:0] d, vn, un, num, q, z;
    int idx;
    bit on_grid;
    r.hit = 0;
    r.interp = NODATA;
    on_grid = (it.row < ROWS) && (it.col < COLS);
    idx = it.row * COLS + it.col;
    if (it.func == FUNC_TRI) begin
      px = $signed({1'b0, sp_x}) * $signed({1'b0, it.col}) + org_x;
      py = $signed({1'b0, sp_y}) * $signed({1'b0, it.row}) + org_y;
      ax = it.v[0]; ay = it.v[1]; az = it.v[2];
      ux = it.v[3] - ax; uy = it.v[4] - ay; uz = it.v[5] - az;
      vx = it.v[6] - ax; vy = it.v[7] - ay; vz = it.v[8] - az;
      dpx = px - ax; dpy = py - ay;
      d = vx * uy - vy * ux;
      vn = dpx * uy - dpy * ux;
      un = dpy * vx - dpx * vy;
      if (d < 0) begin
        d = -d; vn = -vn; un = -un;
      end
      if (d != 0 && un >= 0 && vn >= 0 && un + vn <= d) begin
        num = un * uz + vn * vz;
        q = num / d;  // SV division truncates toward zero
        z = az + q;
        if (z > 128'sd2147483647) z = 128'sd2147483647;
        if (z < -128'sd2147483648) z = -128'sd2147483648;
        r.hit = 1;
        r.interp = z[31:0];
        if (on_grid && r.interp > grid_q8[idx]) grid_q8[idx] = r.interp;
      end
    end else if (it.func == FUNC_CLEAR && on_grid) begin
      grid_q8[idx] = NODATA;
    end
    r.cell_val = on_grid ? grid_q8[idx] : NODATA;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_SPACING_X: sp_x = val[30:0];
      REG_SPACING_Y: sp_y = val[30:0];
      REG_ORIGIN_X:  org_x = val;
      default:       org_y = val;
    endcase
  endtask

  // block must be idle: stop driving, wait for all results, plus some slack
  task automatic drain_heights();
    s_axis_tvalid <= 0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_item(tri_item_t it, bit has_exp, height_res_t exp);
    height_res_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    p = predict_height(it);
    if (has_exp && (p.hit !== exp.hit || p.interp !== exp.interp ||
                    p.cell_val !== exp.cell_val)) begin
      $display("%0t: table row disagrees with predictor: exp %0d/%0d/%0d got %0d/%0d/%0d",
               $time, exp.hit, exp.interp, exp.cell_val, p.hit, p.interp, p.cell_val);
      errors++;
    end
    if (has_exp) p = exp;
    pending_heights.push_back(p);
    s_axis_tvalid <= 1;
    s_axis_tuser <= it.func;
    s_axis_tdata <= {it.v[8], it.v[7], it.v[6], it.v[5], it.v[4], it.v[3],
                     it.v[2], it.v[1], it.v[0], it.col, it.row};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic signed [31:0] rand_q8();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 80000)) - 32'sd20000;
    endcase
  endfunction

  // mostly triangles that cover the post, with random heights
  function automatic tri_item_t rand_item();
    tri_item_t it;
    int k;
    logic signed [63:0] px, py;
    k = $urandom_range(0, 9);
    it.func = (k < 7) ? FUNC_TRI : (k == 7) ? FUNC_READ : (k == 8) ? FUNC_CLEAR : 2'd3;
    it.row = 8'(($urandom_range(0, 1)) ? $urandom_range(0, 7) : $urandom_range(0, 255));
    it.col = 8'(($urandom_range(0, 1)) ? $urandom_range(0, 7) : $urandom_range(0, 255));
    for (int i = 0; i < 9; i++) it.v[i] = rand_q8();
    if ($urandom_range(0, 3) != 0) begin
      px = $signed({1'b0, sp_x}) * $signed({1'b0, it.col}) + org_x;
      py = $signed({1'b0, sp_y}) * $signed({1'b0, it.row}) + org_y;
      it.v[0] = 32'(px - $urandom_range(0, 3000)); it.v[1] = 32'(py - $urandom_range(0, 3000));
      it.v[3] = 32'(px + $urandom_range(0, 3000)); it.v[4] = 32'(py - $urandom_range(0, 3000));
      it.v[6] = 32'(px + $urandom_range(0, 3000) - 1500);
      it.v[7] = 32'(py + $urandom_range(0, 3000));
      if ($urandom_range(0, 9) == 0) begin  // degenerate: collinear
        it.v[6] = it.v[0]; it.v[7] = it.v[1];
      end
    end
    return it;
  endfunction

  // output side: per-result stall draw, compare with oldest expectation
  always @(posedge clk) begin
    height_res_t e;
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_wait > 0) out_wait--;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_heights.size() == 0) begin
          $display("%0t: unexpected result %h/%h", $time, m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          e = pending_heights.pop_front();
          if (m_axis_tuser !== e.hit) begin
            $display("%0t: hit exp %0d got %0d", $time, e.hit, m_axis_tuser); errors++;
          end
          if ($signed(m_axis_tdata[31:0]) !== e.interp) begin
            $display("%0t: interp exp %0d got %0d", $time, e.interp,
                     $signed(m_axis_tdata[31:0])); errors++;
          end
          if ($signed(m_axis_tdata[63:32]) !== e.cell_val) begin
            $display("%0t: cell exp %0d got %0d", $time, e.cell_val,
                     $signed(m_axis_tdata[63:32])); errors++;
          end
        end
        // some stretches run with no stall at all
        out_wait = ((cycles / 4000) % 3 == 0) ? 0 : int'($urandom_range(0, 16));
      end
      m_axis_tready <= (out_wait == 0);
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("triangle_height_max_raster_test: done, errors");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    dir_row_t dr;
    tri_item_t it;
    height_res_t none;
    for (int i = 0; i < ROWS*COLS; i++) grid_q8[i] = NODATA;
    sp_x = 256; sp_y = 256; org_x = 0; org_y = 0;
    none.hit = 0; none.interp = NODATA; none.cell_val = NODATA;
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed table: {func,row,col, ax ay az bx by bz cx cy cz}
    for (int i = 0; i < 14; i++) begin
      dr.has_exp = 0;
      dr.exp = none;
      dr.item.row = 2; dr.item.col = 3;
      for (int j = 0; j < 9; j++) dr.item.v[j] = 0;
      // unit-ish triangle covering post (3,2) at 1.0 spacing
      dr.item.v[0] = 0; dr.item.v[1] = 0; dr.item.v[2] = 100 * 256;
      dr.item.v[3] = 2560; dr.item.v[4] = 0; dr.item.v[5] = 200 * 256;
      dr.item.v[6] = 0; dr.item.v[7] = 2560; dr.item.v[8] = -5 * 256;
      dr.item.func = FUNC_TRI;
      case (i)
        0: begin dr.item.func = FUNC_READ; dr.has_exp = 1; end     // fresh cell
        1: ;                                                        // hit
        2: dr.item.func = FUNC_READ;
        3: begin dr.item.func = FUNC_CLEAR; dr.has_exp = 1; end
        4: begin dr.item.func = 2'd3; dr.has_exp = 1; end           // unused selector
        5: begin dr.item.v[6] = 5120; dr.item.v[7] = 0; dr.has_exp = 1; end // degenerate
        6: begin dr.item.row = 200; dr.has_exp = 1; end             // outside triangle
        7: begin dr.item.row = 0; dr.item.col = 0; end              // vertex exactly
        8: begin dr.item.row = 255; dr.item.col = 255;
             for (int j = 0; j < 9; j += 3) dr.item.v[j] = 32'sh7fffffff; end
        9: begin dr.item.v[2] = 32'sh7fffffff; dr.item.v[5] = 32'sh7fffffff;
             dr.item.v[8] = 32'sh7fffffff; end                      // all heights at the maximum
        10: begin dr.item.v[2] = 32'sh80000000; dr.item.v[5] = 32'sh7fffffff;
             dr.item.v[8] = 32'sh80000000; end
        11: begin dr.item.v[3] = 0; dr.item.v[4] = 2560;
             dr.item.v[6] = 2560; dr.item.v[7] = 0; end             // swapped vertices, positive d
        12: begin dr.item.v[0] = 32'sh80000000; dr.item.v[1] = 32'sh80000000;
             dr.item.v[3] = 32'sh7fffffff; dr.item.v[4] = 32'sh80000000;
             dr.item.v[6] = 32'sh80000000; dr.item.v[7] = 32'sh7fffffff; end
        default: dr.item.func = FUNC_READ;
      endcase
      dir_rows.push_back(dr);
    end
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp);

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      drain_heights();
      case (ph)
        0: ;
        1: begin write_reg(REG_SPACING_X, 1); write_reg(REG_SPACING_Y, 1);
             write_reg(REG_ORIGIN_X, 32'h80000000); write_reg(REG_ORIGIN_Y, 32'h7fffffff); end
        2: begin write_reg(REG_SPACING_X, 32'h7fffffff); write_reg(REG_SPACING_Y, 32'h7fffffff);
             write_reg(REG_ORIGIN_X, 32'h7fffffff); write_reg(REG_ORIGIN_Y, 32'h80000000); end
        default: begin
          write_reg(REG_SPACING_X, $urandom_range(1, 4096));
          write_reg(REG_SPACING_Y, $urandom_range(1, 4096));
          write_reg(REG_ORIGIN_X, $urandom());
          write_reg(REG_ORIGIN_Y, $urandom());
        end
      endcase
      for (int n = 0; n < 256; n++) begin
        it = rand_item();
        send_item(it, 0, none);
      end
    end

    drain_heights();
    if (errors == 0) begin
      $display("triangle_height_max_raster_test: done, clean");
    end else begin
      $display("triangle_height_max_raster_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/thmr_pkg.sv
rtl/thmr_ctrl.sv
rtl/thmr_dp.sv
rtl/triangle_height_max_raster.sv
tb/sv/triangle_height_max_raster_test.sv
